FILE: src/hcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg: shared types and constants of the 4x4 mod-29 hill cipher block
// Alphabet mapping, key matrix layout and reset keys.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int unsigned HILL_MOD = 29;

	// reciprocal of the modulus, exact for row sums below 2**12
	localparam int unsigned RECIP_SHIFT = 14;
	localparam logic [9:0]  RECIP_MUL   = 10'd565;

	typedef logic [4:0]  sym_idx_t;
	typedef logic [11:0] row_sum_t;
	typedef logic [6:0]  quot_t;
	typedef logic [6:0]  ascii_t;

	// one matrix row, column 0 in the low bits
	typedef sym_idx_t [3:0] key_row_t;
	typedef key_row_t [3:0] key_mat_t;
	typedef sym_idx_t [3:0] idx_vec_t;

	typedef struct packed {
		key_mat_t enc;
		key_mat_t dec;
	} key_set_t;

	// configuration register indexes
	localparam logic [3:0] REG_ENC_ROW0 = 4'd0;
	localparam logic [3:0] REG_DEC_ROW0 = 4'd4;
	localparam logic [3:0] NUM_KEY_REGS = 4'd8;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic [7:0][19:0] KEY_RESET = {
		20'd913201, 20'd183668, 20'd450214, 20'd401802,
		20'd517217, 20'd447565, 20'd647352, 20'd56713
	};

	localparam logic [7:0] CHR_STAR    = 8'h2A;
	localparam logic [7:0] CHR_A       = 8'h41;
	localparam logic [7:0] CHR_Z       = 8'h5A;
	localparam logic [7:0] CHR_BRACKET = 8'h5D;
	localparam logic [7:0] CHR_PERCENT = 8'h25;

	localparam sym_idx_t IDX_BRACKET = 5'd27;
	localparam sym_idx_t IDX_PERCENT = 5'd28;
	localparam sym_idx_t IDX_STAR    = 5'd0;

	// anything outside the alphabet, lowercase included, maps to the star
	function automatic sym_idx_t index_of(input logic [7:0] c);
		sym_idx_t idx;
		logic [7:0] ofs;
		ofs = c - (CHR_A - 8'd1);
		idx = IDX_STAR;
		if (c >= CHR_A && c <= CHR_Z) begin
			idx = ofs[4:0];
		end else if (c == CHR_BRACKET) begin
			idx = IDX_BRACKET;
		end else if (c == CHR_PERCENT) begin
			idx = IDX_PERCENT;
		end
		return idx;
	endfunction

	function automatic ascii_t symbol_of(input sym_idx_t r);
		ascii_t ch;
		ascii_t ofs;
		ofs = ascii_t'(CHR_A) - 7'd1 + {2'b00, r};
		if (r == IDX_STAR) begin
			ch = CHR_STAR[6:0];
		end else if (r == IDX_BRACKET) begin
			ch = CHR_BRACKET[6:0];
		end else if (r == IDX_PERCENT) begin
			ch = CHR_PERCENT[6:0];
		end else begin
			ch = ofs;
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: src/hcb_key_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_key_regs: key matrix register file
// Eight 20-bit rows, encrypt rows first, written through a plain write port.
// ----------------------------------------------------------------------------
module hcb_key_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [3:0]          wr_index,
	input  wire logic [19:0]         wr_data,
	output hcb_pkg::key_set_t        keys
);

	hcb_pkg::key_row_t [7:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= hcb_pkg::KEY_RESET;
		end else if (wr_en && wr_index < hcb_pkg::NUM_KEY_REGS) begin
			key_q[wr_index[2:0]] <= hcb_pkg::key_row_t'(wr_data);
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			keys.enc[r] = key_q[hcb_pkg::REG_ENC_ROW0[2:0] + 3'(r)];
			keys.dec[r] = key_q[hcb_pkg::REG_DEC_ROW0[2:0] + 3'(r)];
		end
	end

endmodule
`default_nettype wire

FILE: src/hcb_row_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_row_unit: one output character
// Dot product of a key row with the index vector, reduced mod 29 and mapped
// back to the alphabet over three register stages.
// ----------------------------------------------------------------------------
module hcb_row_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s3,
	input  hcb_pkg::key_row_t        row,
	input  hcb_pkg::idx_vec_t        vec,
	output hcb_pkg::ascii_t          out_char
);

	hcb_pkg::row_sum_t sum_s2;
	hcb_pkg::row_sum_t sum_s3;
	hcb_pkg::quot_t    quot_s3;
	hcb_pkg::ascii_t   char_s4;

	hcb_pkg::row_sum_t sum_d;
	logic [21:0]       recip_prod;
	logic [11:0]       quot_x29;
	hcb_pkg::row_sum_t rem_full;
	hcb_pkg::sym_idx_t rem;

	always_comb begin
		sum_d = '0;
		for (int c = 0; c < 4; c++) begin
			sum_d = sum_d + hcb_pkg::row_sum_t'(row[c]) * hcb_pkg::row_sum_t'(vec[c]);
		end
	end

	// floor(sum / 29) by multiply and shift
	assign recip_prod = 22'(sum_s2) * 22'(hcb_pkg::RECIP_MUL);

	assign quot_x29 = 12'(quot_s3) * 12'(hcb_pkg::HILL_MOD);
	assign rem_full = sum_s3 - quot_x29;
	assign rem      = rem_full[4:0];

	always_ff @(posedge clk) begin
		sum_s2  <= sum_d;
		sum_s3  <= sum_s2;
		quot_s3 <= recip_prod[hcb_pkg::RECIP_SHIFT +: 7];
		char_s4 <= hcb_pkg::symbol_of(rem);
	end

	assign out_char = char_s4;

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rem_full < 12'(hcb_pkg::HILL_MOD)))
		else $error("row residue out of range");

endmodule
`default_nettype wire

FILE: src/hill_cipher_block_4x4_mod29_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hill_cipher_block_4x4_mod29_unit: 4x4 hill cipher over a 29-symbol alphabet
// Encrypts or decrypts one four-character word per cycle.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high; busy stays low, so
// a new word may follow every cycle. Its result appears on out_char0..3 with
// done high for exactly one cycle; the receiver cannot stall and must take it
// then. Four register stages: input indexes, row dot products, reciprocal
// quotient, residue and character map. Key rows are written through wr_en /
// wr_index / wr_data; the user must do so only while no word is in flight,
// the block does not enforce it. Indexes beyond the eight rows are ignored.
// ----------------------------------------------------------------------------
module hill_cipher_block_4x4_mod29_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [7:0]  text_char0,
	input  wire logic [7:0]  text_char1,
	input  wire logic [7:0]  text_char2,
	input  wire logic [7:0]  text_char3,
	output logic             done,
	output logic [6:0]       out_char0,
	output logic [6:0]       out_char1,
	output logic [6:0]       out_char2,
	output logic [6:0]       out_char3,
	input  wire logic        wr_en,
	input  wire logic [3:0]  wr_index,
	input  wire logic [19:0] wr_data
);

	hcb_pkg::key_set_t keys;
	hcb_pkg::key_mat_t mat;
	hcb_pkg::idx_vec_t vec_s1;
	logic              opcode_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic              accept;
	hcb_pkg::ascii_t [3:0] chars;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	hcb_key_regs u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.keys     (keys)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			vec_s1[0] <= hcb_pkg::index_of(text_char0);
			vec_s1[1] <= hcb_pkg::index_of(text_char1);
			vec_s1[2] <= hcb_pkg::index_of(text_char2);
			vec_s1[3] <= hcb_pkg::index_of(text_char3);
		end
	end

	assign mat = (opcode_s1 == hcb_pkg::OP_DECRYPT) ? keys.dec : keys.enc;

	for (genvar r = 0; r < 4; r++) begin : g_row
		hcb_row_unit u_row (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_s3 (valid_s3),
			.row      (mat[r]),
			.vec      (vec_s1),
			.out_char (chars[r])
		);
	end

	assign done      = valid_s4;
	assign out_char0 = chars[0];
	assign out_char1 = chars[1];
	assign out_char2 = chars[2];
	assign out_char3 = chars[3];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted word did not complete after four cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("done without a matching accepted word");

	a_done_is_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_char0 >= hcb_pkg::CHR_PERCENT[6:0]
			&& out_char0 <= hcb_pkg::CHR_BRACKET[6:0]))
		else $error("result character outside the alphabet range");

endmodule
`default_nettype wire

FILE: tb/hill_cipher_block_4x4_mod29_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_block_4x4_mod29_unit_tb: self-checking bench for the hill cipher
// Drives four-character words with random opcodes and idle bursts. It loads
// several key sets: reset, all-zero, all-ones, identity and random. Each word
// is predicted at the accepting edge and checked lane by lane on done.
// ----------------------------------------------------------------------------
module hill_cipher_block_4x4_mod29_unit_tb;

	typedef logic [3:0][7:0]  text_in_t;
	typedef logic [3:0][6:0]  text_out_t;
	typedef logic [7:0][19:0] key_rows_t;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        opcode = hcb_pkg::OP_ENCRYPT;
	logic [7:0]  text_char0 = '0;
	logic [7:0]  text_char1 = '0;
	logic [7:0]  text_char2 = '0;
	logic [7:0]  text_char3 = '0;
	logic        wr_en = 1'b0;
	logic [3:0]  wr_index = '0;
	logic [19:0] wr_data = '0;
	logic        busy;
	logic        done;
	logic [6:0]  out_char0;
	logic [6:0]  out_char1;
	logic [6:0]  out_char2;
	logic [6:0]  out_char3;

	key_rows_t   key_model;
	text_out_t   pending_blocks[$];
	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          idle_on = 1'b1;

	hill_cipher_block_4x4_mod29_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.text_char0 (text_char0),
		.text_char1 (text_char1),
		.text_char2 (text_char2),
		.text_char3 (text_char3),
		.done       (done),
		.out_char0  (out_char0),
		.out_char1  (out_char1),
		.out_char2  (out_char2),
		.out_char3  (out_char3),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always #2 clk = ~clk;

	function automatic logic [4:0] alpha_index(input logic [7:0] ch);
		logic [7:0] ofs;
		ofs = ch - hcb_pkg::CHR_A + 8'd1;
		if (ch >= hcb_pkg::CHR_A && ch <= hcb_pkg::CHR_Z) begin
			return ofs[4:0];
		end else if (ch == hcb_pkg::CHR_BRACKET) begin
			return hcb_pkg::IDX_BRACKET;
		end else if (ch == hcb_pkg::CHR_PERCENT) begin
			return hcb_pkg::IDX_PERCENT;
		end
		return hcb_pkg::IDX_STAR;
	endfunction

	function automatic logic [6:0] alpha_symbol(input int unsigned res);
		logic [6:0] ch;
		ch = hcb_pkg::CHR_A[6:0] - 7'd1 + 7'(res);
		if (res == hcb_pkg::IDX_STAR) begin
			ch = hcb_pkg::CHR_STAR[6:0];
		end else if (res == hcb_pkg::IDX_BRACKET) begin
			ch = hcb_pkg::CHR_BRACKET[6:0];
		end else if (res == hcb_pkg::IDX_PERCENT) begin
			ch = hcb_pkg::CHR_PERCENT[6:0];
		end
		return ch;
	endfunction

	// vector times the selected matrix, each row sum reduced mod 29
	function automatic text_out_t hill_block(input logic op, input text_in_t txt);
		text_out_t   res;
		logic [19:0] row;
		int unsigned sum;
		int unsigned base;
		base = (op == hcb_pkg::OP_DECRYPT) ? 4 : 0;
		for (int r = 0; r < 4; r++) begin
			row = key_model[base + r];
			sum = 0;
			for (int c = 0; c < 4; c++) begin
				sum += int'(row[5*c +: 5]) * int'(alpha_index(txt[c]));
			end
			res[r] = alpha_symbol(sum % hcb_pkg::HILL_MOD);
		end
		return res;
	endfunction

	function automatic logic [7:0] random_char();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick <= 6) begin
			return {1'b0, alpha_symbol($urandom_range(0, hcb_pkg::HILL_MOD - 1))};
		end else if (pick == 7) begin
			return 8'h61 + 8'($urandom_range(0, 25));
		end
		return 8'($urandom);
	endfunction

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// prediction at the accepting edge, check on done, key tracking on writes
	always @(posedge clk) begin : word_monitor
		text_out_t got;
		text_out_t want;
		text_in_t  txt;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				moved = 1'b1;
				got = {out_char3, out_char2, out_char1, out_char0};
				if (pending_blocks.size() == 0) begin
					report($sformatf("result word with none pending: %h", got));
				end else begin
					want = pending_blocks.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (got[i] !== want[i]) begin
							report($sformatf("out_char%0d got %h want %h", i, got[i], want[i]));
						end
					end
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				txt = {text_char3, text_char2, text_char1, text_char0};
				pending_blocks.push_back(hill_block(opcode, txt));
			end
			if (wr_en && wr_index < hcb_pkg::NUM_KEY_REGS) begin
				key_model[wr_index] = wr_data;
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_word(input logic op, input text_in_t txt);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		text_char0 <= txt[0];
		text_char1 <= txt[1];
		text_char2 <= txt[2];
		text_char3 <= txt[3];
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// every row written, then one write past the last row that must be ignored
	task automatic load_keys(input key_rows_t rows);
		for (int i = 0; i < 8; i++) begin
			wr_en    <= 1'b1;
			wr_index <= 4'(i);
			wr_data  <= rows[i];
			@(posedge clk);
		end
		wr_index <= hcb_pkg::NUM_KEY_REGS + 4'($urandom_range(0, 7));
		wr_data  <= 20'($urandom);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send_random(input int count);
		text_in_t txt;
		for (int n = 0; n < count; n++) begin
			for (int c = 0; c < 4; c++) txt[c] = random_char();
			send_word(1'($urandom), txt);
		end
	endtask

	task automatic test_reset_keys();
		text_in_t words[$];
		words = '{
			{4{hcb_pkg::CHR_STAR}}, {4{hcb_pkg::CHR_A}}, {4{hcb_pkg::CHR_Z}},
			{4{hcb_pkg::CHR_PERCENT}},
			{hcb_pkg::CHR_BRACKET, hcb_pkg::CHR_PERCENT,
				hcb_pkg::CHR_BRACKET, hcb_pkg::CHR_PERCENT},
			"ABCD", "WXYZ", "abcz", "@[\\^", "$&)+",
			32'h00000000, 32'hFFFFFFFF, 32'h80C1DDA5, 32'hAAE5DB7F
		};
		// both opcodes on the first eight words, the rest encrypt only
		for (int i = 0; i < words.size(); i++) begin
			send_word(hcb_pkg::OP_ENCRYPT, words[i]);
			if (i < 8) send_word(hcb_pkg::OP_DECRYPT, words[i]);
		end
		drain();
	endtask

	task automatic test_key_extremes();
		key_rows_t ident;
		for (int r = 0; r < 8; r++) begin
			ident[r] = '0;
			ident[r][5*(r%4) +: 5] = 5'd1;
		end
		// all-zero keys: every lane collapses to the star
		load_keys('0);
		send_random(8);
		drain();
		// all entries 31 with the largest index gives the biggest row sum
		load_keys({8{20'hFFFFF}});
		send_word(hcb_pkg::OP_ENCRYPT, {4{hcb_pkg::CHR_PERCENT}});
		send_word(hcb_pkg::OP_DECRYPT, {4{hcb_pkg::CHR_PERCENT}});
		send_random(8);
		drain();
		load_keys(ident);
		send_random(10);
		drain();
	endtask

	task automatic test_random_keys();
		key_rows_t rows;
		for (int k = 0; k < 8; k++) begin
			for (int r = 0; r < 8; r++) rows[r] = 20'($urandom);
			idle_on = (k != 5);
			load_keys(rows);
			send_random(100);
			drain();
		end
	endtask

	task automatic test_back_to_back();
		key_rows_t rows;
		for (int r = 0; r < 8; r++) rows[r] = 20'($urandom);
		idle_on = 1'b0;
		load_keys(rows);
		send_random(100);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) key_model[i] = hcb_pkg::KEY_RESET[i];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_keys();
		test_key_extremes();
		test_random_keys();
		test_back_to_back();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: hill_cipher_block_4x4_mod29_unit.f
src/hcb_pkg.sv
src/hcb_key_regs.sv
src/hcb_row_unit.sv
src/hill_cipher_block_4x4_mod29_unit.sv
tb/hill_cipher_block_4x4_mod29_unit_tb.sv
